>>> src/ppmrb_pkg.sv
// ----------------------------------------------------------------------------
// Polar point min-range binner package
// Shared constants, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package ppmrb_pkg;

  localparam int NUM_BINS_DEF  = 1024;
  localparam int COORD_BITS_DEF = 20;
  localparam int VECTOR_ITER_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE   = 3'd5;
  localparam int CFG_DATA_W = 20;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_RANGE_REJ  = 3'd1;
  localparam logic [2:0] ST_ANGLE_REJ  = 3'd2;
  localparam logic [2:0] ST_BEYOND_USE = 3'd3;
  localparam logic [2:0] ST_NOT_CLOSER = 3'd4;

  localparam logic [19:0] NO_RETURN = 20'hFFFFF;
  localparam logic [15:0] INV_GAIN  = 16'd39797;
  localparam int GUARD_BITS = 8;
  localparam int ACC_W = 22;
  localparam int ITER_W = 5;

  function automatic logic [20:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [20:0] v;
    case (i)
      5'd0: v = 21'd262144;
      5'd1: v = 21'd154753;
      5'd2: v = 21'd81767;
      5'd3: v = 21'd41506;
      5'd4: v = 21'd20834;
      5'd5: v = 21'd10427;
      5'd6: v = 21'd5215;
      5'd7: v = 21'd2608;
      5'd8: v = 21'd1304;
      5'd9: v = 21'd652;
      5'd10: v = 21'd326;
      5'd11: v = 21'd163;
      5'd12: v = 21'd81;
      5'd13: v = 21'd41;
      5'd14: v = 21'd20;
      5'd15: v = 21'd10;
      5'd16: v = 21'd5;
      5'd17: v = 21'd3;
      5'd18: v = 21'd1;
      5'd19: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/ppmrb_if.sv
// ----------------------------------------------------------------------------
// Polar point min-range binner channels
// Point, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ppmrb_in_if #(
  parameter int COORD_BITS = ppmrb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [9:0]                   read_bin;

  modport source (output valid, mode, point_x, point_y, read_bin, input ready);
  modport sink (input valid, mode, point_x, point_y, read_bin, output ready);
endinterface

interface ppmrb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  bin_number;
  logic [19:0] bin_range;

  modport source (output valid, status, bin_number, bin_range, input ready);
  modport sink (input valid, status, bin_number, bin_range, output ready);
endinterface

interface ppmrb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ppmrb_pkg::CFG_IDX_W-1:0]     index;
  logic [ppmrb_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/polar_point_min_range_binner.sv
// ----------------------------------------------------------------------------
// Polar point min-range binner
// Converts points to range and bearing with a shared vectoring unit, bins
// them by bearing and keeps the smallest range in each bin.
//
//   Channel  Role  Transaction
//   in_ch    sink  mode, point_x, point_y, read_bin
//   out_ch   src   status, bin_number, bin_range
//   cfg      sink  index, data (always ready)
//
// An insert runs the vectoring loop, one multiply, a 17-step serial divide and
// a read-modify-write of the bin memory.
// A clear sweeps the whole memory.
// After reset the same sweep runs before in_ch is ready.
// A finished result waits in the output register while out_ch stalls.
// ----------------------------------------------------------------------------
module polar_point_min_range_binner #(
  parameter int NUM_BINS          = ppmrb_pkg::NUM_BINS_DEF,
  parameter int COORD_BITS        = ppmrb_pkg::COORD_BITS_DEF,
  parameter int VECTOR_ITERATIONS = ppmrb_pkg::VECTOR_ITER_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ppmrb_in_if.sink  in_ch,
  ppmrb_out_if.source out_ch,
  ppmrb_cfg_if.sink cfg
);

  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int W       = COORD_BITS + ppmrb_pkg::GUARD_BITS + 3;
  localparam int PROD_W  = W + 16;
  localparam int RF_W    = PROD_W - 24;
  localparam int CMP_W   = (RF_W > 20) ? RF_W : 20;
  localparam int LIM_W   = 18;
  localparam int DIV_W   = 17;
  localparam int DCNT_W  = 5;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_VEC   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_BIN   = 4'd6;
  localparam logic [3:0] S_RDA   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state;

  logic signed [15:0] angle_start;
  logic signed [15:0] angle_end;
  logic [14:0]        angle_step;
  logic [19:0]        range_floor;
  logic [19:0]        range_ceiling;
  logic [10:0]        bins_in_use;

  logic signed [W-1:0]                x;
  logic signed [W-1:0]                y;
  logic signed [ppmrb_pkg::ACC_W-1:0] acc;
  logic [ppmrb_pkg::ITER_W-1:0]       it;
  logic [PROD_W-1:0]                  prod;
  logic [19:0]                        rng;
  logic [DIV_W-1:0]                   quo;
  logic [14:0]                        rem;
  logic [DCNT_W-1:0]                  dcnt;
  logic [BIN_W-1:0]                   addr;
  logic                               rd_mode;
  logic                               clr_report;
  logic [2:0]                         res_status;
  logic [9:0]                         res_bin;
  logic [19:0]                        res_range;

  logic [19:0] mem [NUM_BINS];
  logic [19:0] mem_q;
  logic        mem_we;
  logic [19:0] mem_wd;

  logic                              in_acc;
  logic signed [W-1:0]               px;
  logic signed [W-1:0]               py;
  logic signed [W-1:0]               xs;
  logic signed [W-1:0]               ys;
  logic [W-1:0]                      xc;
  logic [RF_W-1:0]                   rng_full;
  logic [19:0]                       rng_sat;
  logic signed [16:0]                ang;
  logic signed [17:0]                ang_off;
  logic [15:0]                       rem_sh;
  logic [LIM_W-1:0]                  limit;
  logic                              last_bin;

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign px = W'(in_ch.point_x) <<< ppmrb_pkg::GUARD_BITS;
  assign py = W'(in_ch.point_y) <<< ppmrb_pkg::GUARD_BITS;
  assign xs = x >>> it;
  assign ys = y >>> it;
  assign xc = x[W-1] ? '0 : x;

  assign rng_full = RF_W'((prod + PROD_W'(24'h800000)) >> 24);
  assign rng_sat  = (CMP_W'(rng_full) > CMP_W'(ppmrb_pkg::NO_RETURN)) ?
                    ppmrb_pkg::NO_RETURN : 20'(rng_full);
  assign ang      = 17'((acc + ppmrb_pkg::ACC_W'(16)) >>> 5);
  assign ang_off  = 18'(ang) - 18'(angle_start);
  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign limit    = (LIM_W'(bins_in_use) < LIM_W'(NUM_BINS)) ?
                    LIM_W'(bins_in_use) : LIM_W'(NUM_BINS);
  assign last_bin = (addr == BIN_W'(NUM_BINS - 1));

  always_comb begin
    mem_we = 1'b0;
    mem_wd = ppmrb_pkg::NO_RETURN;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_UPD && !rd_mode && rng < mem_q) begin
      mem_we = 1'b1;
      mem_wd = rng;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wd;
    end
    mem_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start   <= -16'sd32768;
      angle_end     <= 16'sd32767;
      angle_step    <= 15'd64;
      range_floor   <= 20'd0;
      range_ceiling <= 20'd1048574;
      bins_in_use   <= 11'd1024;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ppmrb_pkg::REG_ANGLE_START:   angle_start   <= cfg.data[15:0];
        ppmrb_pkg::REG_ANGLE_END:     angle_end     <= cfg.data[15:0];
        ppmrb_pkg::REG_ANGLE_STEP:    angle_step    <= cfg.data[14:0];
        ppmrb_pkg::REG_RANGE_FLOOR:   range_floor   <= cfg.data;
        ppmrb_pkg::REG_RANGE_CEILING: range_ceiling <= cfg.data;
        ppmrb_pkg::REG_BINS_IN_USE:   bins_in_use   <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      clr_report <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            res_status <= ppmrb_pkg::ST_DONE;
            res_bin    <= '0;
            res_range  <= ppmrb_pkg::NO_RETURN;
            rd_mode    <= 1'b0;
            case (in_ch.mode)
              ppmrb_pkg::MODE_CLEAR: begin
                addr       <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              ppmrb_pkg::MODE_INSERT: begin
                it  <= '0;
                acc <= '0;
                if (in_ch.point_x == '0 && in_ch.point_y == '0) begin
                  x     <= '0;
                  y     <= '0;
                  state <= S_MUL;
                end else begin
                  state <= S_VEC;
                  if (px < 0 && py >= 0) begin
                    x   <= py;
                    y   <= -px;
                    acc <= ppmrb_pkg::ACC_W'(524288);
                  end else if (px < 0) begin
                    x   <= -py;
                    y   <= px;
                    acc <= -ppmrb_pkg::ACC_W'(524288);
                  end else begin
                    x <= px;
                    y <= py;
                  end
                end
              end
              ppmrb_pkg::MODE_READ: begin
                if (LIM_W'(in_ch.read_bin) >= LIM_W'(NUM_BINS)) begin
                  res_status <= ppmrb_pkg::ST_BEYOND_USE;
                  state      <= S_FIN;
                end else begin
                  rd_mode <= 1'b1;
                  addr    <= BIN_W'(in_ch.read_bin);
                  res_bin <= in_ch.read_bin;
                  state   <= S_RDA;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (last_bin) begin
            state      <= clr_report ? S_FIN : S_IDLE;
            clr_report <= 1'b0;
          end
        end
        S_VEC: begin
          if (y > 0) begin
            x   <= x + ys;
            y   <= y - xs;
            acc <= acc + ppmrb_pkg::ACC_W'(ppmrb_pkg::atan_entry(it));
          end else begin
            x   <= x - ys;
            y   <= y + xs;
            acc <= acc - ppmrb_pkg::ACC_W'(ppmrb_pkg::atan_entry(it));
          end
          it <= it + 1'b1;
          if (it == ppmrb_pkg::ITER_W'(VECTOR_ITERATIONS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(xc) * PROD_W'(ppmrb_pkg::INV_GAIN);
          state <= S_CHECK;
        end
        S_CHECK: begin
          rng <= rng_sat;
          if (rng_sat < range_floor || rng_sat > range_ceiling) begin
            res_status <= ppmrb_pkg::ST_RANGE_REJ;
            state      <= S_FIN;
          end else if (ang < 17'(angle_start) || ang > 17'(angle_end)) begin
            res_status <= ppmrb_pkg::ST_ANGLE_REJ;
            state      <= S_FIN;
          end else begin
            quo   <= ang_off[DIV_W-1:0];
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, (angle_step == '0) ? 15'd1 : angle_step}) begin
            rem <= 15'(rem_sh - {1'b0, (angle_step == '0) ? 15'd1 : angle_step});
            quo <= {quo[DIV_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[14:0];
            quo <= {quo[DIV_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DIV_W - 1)) begin
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if (LIM_W'(quo) >= limit) begin
            res_status <= ppmrb_pkg::ST_BEYOND_USE;
            state      <= S_FIN;
          end else begin
            addr    <= BIN_W'(quo);
            res_bin <= quo[9:0];
            state   <= S_RDA;
          end
        end
        S_RDA: state <= S_UPD;
        S_UPD: begin
          if (rd_mode) begin
            res_range <= mem_q;
          end else if (rng < mem_q) begin
            res_range <= rng;
          end else begin
            res_status <= ppmrb_pkg::ST_NOT_CLOSER;
            res_range  <= mem_q;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.status     <= res_status;
            out_ch.bin_number <= res_bin;
            out_ch.bin_range  <= res_range;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  a_reset_sweep: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !in_ch.ready)
    else $error("input ready before the clearing sweep");

  a_reject_payload: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status == ppmrb_pkg::ST_RANGE_REJ ||
                     out_ch.status == ppmrb_pkg::ST_ANGLE_REJ)
    |-> out_ch.bin_number == '0 && out_ch.bin_range == ppmrb_pkg::NO_RETURN)
    else $error("rejected point carries a bin");

  a_store_only_closer: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && mem_we) |-> (rng < mem_q && !rd_mode))
    else $error("bin overwritten without a closer range");

endmodule

>>> tb/polar_point_min_range_binner_test.sv
// ----------------------------------------------------------------------------
// Polar point min-range binner testbench
// Sends clear, insert and read transactions under several register settings
// and random idling on both channels, predicts each result from its own model
// of the vectoring, binning and bin memory, and checks every result in order.
// ----------------------------------------------------------------------------
module polar_point_min_range_binner_test;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  bin_number;
    logic [19:0] bin_range;
  } bin_result_t;

  logic clk;
  logic rst;
  int   error_count;
  bit   no_idle;
  int   stall_left;

  ppmrb_in_if  in_ch();
  ppmrb_out_if out_ch();
  ppmrb_cfg_if cfg_ch();

  polar_point_min_range_binner dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  bin_result_t        pending_results[$];
  logic [19:0]        bin_mirror[1024];
  logic signed [15:0] win_start;
  logic signed [15:0] win_end;
  logic [14:0]        bin_width;
  logic [19:0]        range_low;
  logic [19:0]        range_high;
  logic [10:0]        bins_used;
  longint             atan_steps[16] = '{262144, 154753, 81767, 41506, 20834, 10427,
                                         5215, 2608, 1304, 652, 326, 163, 81, 41,
                                         20, 10};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("polar_point_min_range_binner test failed");
    $finish;
  end

  function automatic void polar_of(input longint px, input longint py,
                                   output logic [19:0] rng, output longint bearing);
    longint x, y, acc, t, xs, ys, prod;
    acc = 0;
    if (px == 0 && py == 0) begin
      rng = '0;
      bearing = 0;
      return;
    end
    x = px * 256;
    y = py * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 524288;
      end else begin
        x = -y; y = t; acc = -524288;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; acc += atan_steps[i];
      end else begin
        x = x - ys; y = y + xs; acc -= atan_steps[i];
      end
    end
    if (x < 0) x = 0;
    prod = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
    rng = (prod > 1048575) ? ppmrb_pkg::NO_RETURN : prod[19:0];
    bearing = (acc + 16) >>> 5;
  endfunction

  function automatic bin_result_t predict_bin_update(input logic [1:0] mode,
      input logic signed [19:0] px, input logic signed [19:0] py, input logic [9:0] rb);
    bin_result_t res;
    logic [19:0] rng;
    longint bearing, idx, limit, width;
    res = '{status: ppmrb_pkg::ST_DONE, bin_number: '0, bin_range: ppmrb_pkg::NO_RETURN};
    case (mode)
      ppmrb_pkg::MODE_CLEAR: begin
        foreach (bin_mirror[i]) bin_mirror[i] = ppmrb_pkg::NO_RETURN;
      end
      ppmrb_pkg::MODE_INSERT: begin
        polar_of(longint'(px), longint'(py), rng, bearing);
        if (rng < range_low || rng > range_high) begin
          res.status = ppmrb_pkg::ST_RANGE_REJ;
        end else if (bearing < longint'(win_start) || bearing > longint'(win_end)) begin
          res.status = ppmrb_pkg::ST_ANGLE_REJ;
        end else begin
          width = (bin_width == 0) ? 1 : longint'(bin_width);
          idx = (bearing - longint'(win_start)) / width;
          limit = (bins_used < 1024) ? longint'(bins_used) : 1024;
          if (idx >= limit) begin
            res.status = ppmrb_pkg::ST_BEYOND_USE;
          end else begin
            res.bin_number = idx[9:0];
            if (rng < bin_mirror[idx]) begin
              bin_mirror[idx] = rng;
            end else begin
              res.status = ppmrb_pkg::ST_NOT_CLOSER;
            end
            res.bin_range = bin_mirror[idx];
          end
        end
      end
      ppmrb_pkg::MODE_READ: begin
        res.bin_number = rb;
        res.bin_range = bin_mirror[rb];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d, wanted %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected transaction, status", out_ch.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
        if (out_ch.bin_number !== want.bin_number)
          report("bin_number", out_ch.bin_number, want.bin_number);
        if (out_ch.bin_range !== want.bin_range)
          report("bin_range", out_ch.bin_range, want.bin_range);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 30)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_point(input logic [1:0] mode, input logic signed [19:0] px,
                            input logic signed [19:0] py, input logic [9:0] rb);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.read_bin <= rb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_bin_update(mode, px, py, rb));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ppmrb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [19:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      ppmrb_pkg::REG_ANGLE_START:   win_start = value[15:0];
      ppmrb_pkg::REG_ANGLE_END:     win_end = value[15:0];
      ppmrb_pkg::REG_ANGLE_STEP:    bin_width = value[14:0];
      ppmrb_pkg::REG_RANGE_FLOOR:   range_low = value;
      ppmrb_pkg::REG_RANGE_CEILING: range_high = value;
      ppmrb_pkg::REG_BINS_IN_USE:   bins_used = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic signed [15:0] a0, input logic signed [15:0] a1,
                         input logic [14:0] st, input logic [19:0] lo,
                         input logic [19:0] hi, input logic [10:0] nb);
    drain();
    write_reg(ppmrb_pkg::REG_ANGLE_START, {4'b0, a0});
    write_reg(ppmrb_pkg::REG_ANGLE_END, {4'b0, a1});
    write_reg(ppmrb_pkg::REG_ANGLE_STEP, {5'b0, st});
    write_reg(ppmrb_pkg::REG_RANGE_FLOOR, lo);
    write_reg(ppmrb_pkg::REG_RANGE_CEILING, hi);
    write_reg(ppmrb_pkg::REG_BINS_IN_USE, {9'b0, nb});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [19:0] random_coord();
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return 20'($signed($urandom_range(0, 4095)) - 2048);
      2: return 20'($signed($urandom_range(0, 262143)) - 131072);
      default: return ($urandom_range(0, 1) != 0) ? 20'sh7FFFF : 20'sh80000;
    endcase
  endfunction

  task automatic random_phase(input int count, input bit forward_bias);
    int r;
    logic signed [19:0] px, py;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 999);
      px = random_coord();
      py = random_coord();
      if (forward_bias && $urandom_range(0, 1) != 0) begin
        px = 20'($urandom_range(1000, 300000));
        py = 20'($signed($urandom_range(0, 20000)) - 10000);
      end
      if (r < 8) send_point(ppmrb_pkg::MODE_CLEAR, px, py, 10'($urandom));
      else if (r < 12) send_point(ppmrb_pkg::MODE_UNUSED, px, py, 10'($urandom));
      else if (r < 130) send_point(ppmrb_pkg::MODE_READ, px, py, 10'($urandom));
      else send_point(ppmrb_pkg::MODE_INSERT, px, py, 10'($urandom));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_special_points();
    send_point(ppmrb_pkg::MODE_INSERT, 20'sd0, 20'sd0, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sh7FFFF, 20'sd0, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sh80000, 20'sh80000, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sh80000, 20'sd0, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sd0, 20'sh7FFFF, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sd0, 20'sh80000, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, -20'sd5000, 20'sd3000, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, -20'sd5000, -20'sd3000, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sh7FFFF, 20'sh7FFFF, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sd2048, 20'sd100, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sd2048, 20'sd100, 10'd0);
    send_point(ppmrb_pkg::MODE_INSERT, 20'sd1024, 20'sd50, 10'd0);
    send_point(ppmrb_pkg::MODE_READ, 20'sd0, 20'sd0, 10'd0);
    send_point(ppmrb_pkg::MODE_READ, 20'sd0, 20'sd0, 10'd1023);
    send_point(ppmrb_pkg::MODE_READ, 20'sd0, 20'sd0, 10'd512);
    send_point(ppmrb_pkg::MODE_UNUSED, 20'sh7FFFF, 20'sh80000, 10'h3FF);
    send_point(ppmrb_pkg::MODE_CLEAR, 20'sd0, 20'sd0, 10'd0);
    send_point(ppmrb_pkg::MODE_READ, 20'sd0, 20'sd0, 10'd512);
  endtask

  task automatic test_default_random();
    random_phase(350, 1'b0);
  endtask

  task automatic test_narrow_window();
    set_all(-16'sd1000, 16'sd1000, 15'd0, 20'd100, 20'd200000, 11'd7);
    random_phase(300, 1'b1);
  endtask

  task automatic test_store_limit();
    set_all(-16'sd32768, 16'sd32767, 15'd1, 20'd0, 20'd1048574, 11'd2047);
    random_phase(250, 1'b1);
    drain();
    repeat (30) @(posedge clk);
  endtask

  task automatic test_extremes();
    set_all(16'sd32767, -16'sd32768, 15'd32767, 20'd1048574, 20'd0, 11'd1);
    random_phase(60, 1'b0);
    set_all(-16'sd32768, 16'sd32767, 15'd32767, 20'd1048574, 20'd1048574, 11'd1);
    random_phase(60, 1'b0);
    set_all(16'sd0, 16'sd32767, 15'd32767, 20'd0, 20'd1048574, 11'd1);
    random_phase(100, 1'b1);
  endtask

  task automatic test_mid_settings();
    set_all(-16'sd16384, 16'sd20000, 15'd40, 20'd50, 20'd700000, 11'd1024);
    random_phase(320, 1'b1);
  endtask

  initial begin
    error_count = 0;
    no_idle = 1'b0;
    stall_left = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = ppmrb_pkg::MODE_CLEAR;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.read_bin = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ppmrb_pkg::REG_ANGLE_START;
    cfg_ch.data = '0;
    foreach (bin_mirror[i]) bin_mirror[i] = ppmrb_pkg::NO_RETURN;
    win_start = -16'sd32768;
    win_end = 16'sd32767;
    bin_width = 15'd64;
    range_low = 20'd0;
    range_high = 20'd1048574;
    bins_used = 11'd1024;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_points();
    test_default_random();
    test_narrow_window();
    test_store_limit();
    test_extremes();
    test_mid_settings();
    drain();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("polar_point_min_range_binner test passed");
    end else begin
      $display("polar_point_min_range_binner test failed");
    end
    $finish;
  end

endmodule
